// ----- sv/lru_pkg.sv -----
// shared constants and types for the lru replacement list
`default_nettype none
package lru_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int RANK_W   = IDX_W;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_EVICT  = 2'd1;
	localparam logic [1:0] MODE_ERASE  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic             load;
		logic             scan;
		logic [IDX_W-1:0] idx;
		logic             commit;
	} lru_cmd_t;

	typedef struct packed {
		logic out_free;
	} lru_sts_t;

endpackage
`default_nettype wire

// ----- sv/lru_ctrl.sv -----
// sequencer: accept, slot scan, commit
`default_nettype none
module lru_ctrl
	import lru_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire lru_sts_t sts,
	output lru_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_UPDATE = 3'b100
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             last_idx;

	assign last_idx = (idx_q == IDX_W'(CAPACITY - 1));
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.idx    = idx_q;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					idx_d    = '0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				idx_d    = idx_q + 1'b1;
				if (last_idx) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				// wait for the result register to be free
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/lru_datapath.sv -----
// slot store, scan match registers, rank update and result register
`default_nettype none
module lru_datapath
	import lru_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lru_cmd_t            cmd,
	output lru_sts_t                 sts,
	input  wire logic [1:0]          mode,
	input  wire logic [KEY_BITS-1:0] key,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               status,
	output logic [KEY_BITS-1:0]      victim_key,
	output logic [CNT_W-1:0]         entry_count
);

	logic [KEY_BITS-1:0] key_slots_q [CAPACITY];
	logic [RANK_W-1:0]   rank_q      [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    count_q;

	logic [1:0]          mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [RANK_W-1:0]   hit_rank_q;
	logic [KEY_BITS-1:0] hit_key_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [KEY_BITS-1:0] victim_q;
	logic [CNT_W-1:0]    out_count_q;

	logic                slot_vld;
	logic                key_match;
	logic                age_match;
	logic                scan_hit;
	logic                full;

	logic                touch, add, drop_evict, drop_erase;
	logic [1:0]          status_d;
	logic [KEY_BITS-1:0] victim_d;
	logic [CNT_W-1:0]    count_d;

	// one slot examined per scan cycle
	assign slot_vld  = valid_q[cmd.idx];
	assign key_match = slot_vld && (key_slots_q[cmd.idx] == key_q);
	assign age_match = slot_vld && ({{(CNT_W-RANK_W){1'b0}}, rank_q[cmd.idx]} == count_q - 1'b1);
	assign scan_hit  = ((mode_q == MODE_INSERT || mode_q == MODE_ERASE) && key_match) ||
	                   ((mode_q == MODE_EVICT) && age_match);
	assign full      = (count_q >= CNT_W'(CAPACITY));

	always_comb begin
		touch      = 1'b0;
		add        = 1'b0;
		drop_evict = 1'b0;
		drop_erase = 1'b0;
		status_d   = ST_OK;
		victim_d   = '0;
		count_d    = count_q;
		unique case (mode_q)
			MODE_INSERT: begin
				if (hit_q) begin
					touch = 1'b1;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					add = 1'b1;
					if (free_found_q) begin
						count_d = count_q + 1'b1;
					end
				end
			end
			MODE_EVICT: begin
				if (count_q == '0 || !hit_q) begin
					status_d = ST_EMPTY;
				end else begin
					drop_evict = 1'b1;
					victim_d   = hit_key_q;
					count_d    = count_q - 1'b1;
				end
			end
			MODE_ERASE: begin
				if (hit_q) begin
					drop_erase = 1'b1;
					count_d    = count_q - 1'b1;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// item registers and scan results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.scan) begin
			if (!hit_q && scan_hit) begin
				hit_q <= 1'b1;
			end
			if (!free_found_q && !slot_vld) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			key_q  <= key;
		end
		if (cmd.scan && !hit_q && scan_hit) begin
			hit_idx_q  <= cmd.idx;
			hit_rank_q <= rank_q[cmd.idx];
			hit_key_q  <= key_slots_q[cmd.idx];
		end
		if (cmd.scan && !free_found_q && !slot_vld) begin
			free_idx_q <= cmd.idx;
		end
	end

	// valid bits and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			if (add && free_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (drop_evict || drop_erase) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// keys and ranks, all slots updated side by side
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (valid_q[i]) begin
					if (touch && rank_q[i] < hit_rank_q) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
					if (add) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
					if (drop_erase && rank_q[i] > hit_rank_q) begin
						rank_q[i] <= rank_q[i] - 1'b1;
					end
				end
			end
			if (touch) begin
				rank_q[hit_idx_q] <= '0;
			end
			if (add && free_found_q) begin
				rank_q[free_idx_q]      <= '0;
				key_slots_q[free_idx_q] <= key_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q    <= status_d;
			victim_q    <= victim_d;
			out_count_q <= count_d;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign victim_key   = victim_q;
	assign entry_count  = out_count_q;

endmodule
`default_nettype wire

// ----- sv/lru_replacer_top.sv -----
// lru replacement list: top level
// operation: the item is accepted, then a serial slot scan examines one slot
// per scan cycle, then a commit updates the ranks and loads the result register
// one item at a time: the input stays stalled from acceptance until the commit;
// a stalled result holds the commit and the input
// reset: arst_n clears valid bits, count and control at once; keys and ranks
// need no clearing since only valid slots are ever read
`default_nettype none
module lru_replacer_top
	import lru_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          mode,
	input  wire logic [KEY_BITS-1:0] key,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               status,
	output logic [KEY_BITS-1:0]      victim_key,
	output logic [CNT_W-1:0]         entry_count
);

	lru_cmd_t cmd;
	lru_sts_t sts;

	lru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lru_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.key         (key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.victim_key  (victim_key),
		.entry_count (entry_count)
	);

endmodule
`default_nettype wire

// ----- sv/lru_checker.sv -----
// port-level checks for the lru replacement list, bound to the top level
`default_nettype none
module lru_checker
	import lru_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [1:0]          status,
	input wire logic [KEY_BITS-1:0] victim_key,
	input wire logic [CNT_W-1:0]    entry_count
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(victim_key) && $stable(entry_count))
		else $error("stalled result changed");

	// one item at a time: an accepted item blocks the input next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting an item");

	// victim key zero on any failed operation
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> victim_key == '0)
		else $error("victim key set on failed operation");

	// full status only when the store is full
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY))
		else $error("full status with store not full");

	// empty status only when nothing is held
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> entry_count == '0)
		else $error("empty status with keys held");

endmodule

bind lru_replacer_top lru_checker u_lru_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.victim_key  (victim_key),
	.entry_count (entry_count)
);
`default_nettype wire
